// File: rtl/vxrot_pkg.sv
// Shared types, constants and tables of the vertex axis rotation block.
package vxrot_pkg;

    // Fixed field widths
    localparam int ANGLE_WIDTH = 16;
    localparam int CORDIC_WIDTH = 32;
    localparam int ATAN_TABLE_SIZE = 24;

    // Angle units are 1/16 degree
    localparam int DEG_FULL_INT = 5760;
    localparam logic [13:0] DEG_FULL = 14'(DEG_FULL_INT);
    localparam logic [13:0] DEG_HALF = 14'd2880;
    localparam logic [13:0] DEG_QUARTER = 14'd1440;
    localparam logic [13:0] DEG_3QUARTER = 14'd4320;

    // CORDIC gain 0.60725293 in Q30
    localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    // Arctangent of 2^-i in 2^-24 degree
    localparam logic signed [CORDIC_WIDTH-1:0] ATAN_DEG24 [ATAN_TABLE_SIZE] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489089, 32'sd119537938,
        32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
        32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
        32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
        32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
        32'sd917,       32'sd458,       32'sd229,       32'sd115
    };

    // Rotation axis codes
    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_PASS = 2'd3
    } axis_t;

    // Control that travels with each item down the pipeline
    typedef struct packed {
        logic  valid;
        logic  flip;
        axis_t axis;
    } cell_ctrl_t;

    // CORDIC working state: x, y in Q30, z in 2^-24 degree
    typedef struct packed {
        logic signed [CORDIC_WIDTH-1:0] x;
        logic signed [CORDIC_WIDTH-1:0] y;
        logic signed [CORDIC_WIDTH-1:0] z;
    } cordic_t;

    // Residue of (upper angle byte * 256) modulo a full turn
    typedef logic [12:0] hi_mod_tbl_t [256];

    function automatic hi_mod_tbl_t build_hi_mod_tbl();
        hi_mod_tbl_t tbl;
        int          v;
        for (int i = 0; i < 256; i++) begin
            v = (((i < 128) ? i : i - 256) * 256) % DEG_FULL_INT;
            if (v < 0) begin
                v = v + DEG_FULL_INT;
            end
            tbl[i] = 13'(v);
        end
        return tbl;
    endfunction

    localparam hi_mod_tbl_t HI_MOD_TBL = build_hi_mod_tbl();

endpackage

// File: rtl/vxrot_angle_fold.sv
// Angle reduction to +-90 degrees and CORDIC seed, two pipeline stages.
module vxrot_angle_fold #(
    parameter int CW = 16
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     en,
    input  logic                                     in_valid,
    input  logic [vxrot_pkg::ANGLE_WIDTH-1:0]        angle,
    input  vxrot_pkg::axis_t                         axis,
    input  logic [3*CW-1:0]                          vtx,
    output vxrot_pkg::cell_ctrl_t                    ctrl_out,
    output vxrot_pkg::cordic_t                       st_out,
    output logic [3*CW-1:0]                          vtx_out
);
    import vxrot_pkg::*;

    logic             valid_reg;
    axis_t            axis_reg;
    logic [3*CW-1:0]  vtx_reg;
    logic [12:0]      res_reg;
    logic [12:0]      res_next;
    logic [13:0]      res_sum;

    cell_ctrl_t       ctrl_next;
    logic             ctrl_valid_reg;
    logic             ctrl_flip_reg;
    axis_t            ctrl_axis_reg;
    cordic_t          st_reg;
    cordic_t          st_next;
    logic [3*CW-1:0]  vtx2_reg;
    logic [13:0]      res_ext;
    logic [13:0]      fold_val;
    logic [11:0]      fold_a;

    // Take the angle modulo a full turn: byte residue plus low byte
    always_comb begin
        res_sum = {1'b0, HI_MOD_TBL[angle[15:8]]} + {6'b0, angle[7:0]};
        if (res_sum >= DEG_FULL) begin
            res_next = 13'(res_sum - DEG_FULL);
        end else begin
            res_next = res_sum[12:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg  <= res_next;
            axis_reg <= axis;
            vtx_reg  <= vtx;
        end
    end

    // Fold [0, 360) into [-90, 90], marking the half turns that negate
    always_comb begin
        res_ext = {1'b0, res_reg};
        ctrl_next.valid = valid_reg;
        ctrl_next.axis  = axis_reg;
        if (res_ext <= DEG_QUARTER) begin
            fold_val       = res_ext;
            ctrl_next.flip = 1'b0;
        end else if (res_ext < DEG_3QUARTER) begin
            fold_val       = res_ext - DEG_HALF;
            ctrl_next.flip = 1'b1;
        end else begin
            fold_val       = res_ext - DEG_FULL;
            ctrl_next.flip = 1'b0;
        end
        fold_a     = fold_val[11:0];
        st_next.x  = CORDIC_GAIN_Q30;
        st_next.y  = '0;
        st_next.z  = {fold_a, 20'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_valid_reg <= 1'b0;
        end else if (en) begin
            ctrl_valid_reg <= ctrl_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctrl_flip_reg <= ctrl_next.flip;
            ctrl_axis_reg <= ctrl_next.axis;
            st_reg        <= st_next;
            vtx2_reg      <= vtx_reg;
        end
    end

    assign ctrl_out = '{valid: ctrl_valid_reg, flip: ctrl_flip_reg, axis: ctrl_axis_reg};
    assign st_out   = st_reg;
    assign vtx_out  = vtx2_reg;

endmodule

// File: rtl/vxrot_cordic_cell.sv
// One CORDIC micro-rotation cell of the sine and cosine chain.
module vxrot_cordic_cell #(
    parameter int CW        = 16,
    parameter int STAGE_IDX = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  vxrot_pkg::cell_ctrl_t ctrl_in,
    input  vxrot_pkg::cordic_t    st_in,
    input  logic [3*CW-1:0]       vtx_in,
    output vxrot_pkg::cell_ctrl_t ctrl_out,
    output vxrot_pkg::cordic_t    st_out,
    output logic [3*CW-1:0]       vtx_out
);
    import vxrot_pkg::*;

    logic            valid_reg;
    logic            flip_reg;
    axis_t           axis_reg;
    cordic_t         st_reg;
    cordic_t         st_next;
    logic [3*CW-1:0] vtx_reg;
    logic signed [CORDIC_WIDTH-1:0] dx;
    logic signed [CORDIC_WIDTH-1:0] dy;

    // Rotate toward zero residual angle with floor shifts
    always_comb begin
        dx = st_in.y >>> STAGE_IDX;
        dy = st_in.x >>> STAGE_IDX;
        if (!st_in.z[CORDIC_WIDTH-1]) begin
            st_next.x = st_in.x - dx;
            st_next.y = st_in.y + dy;
            st_next.z = st_in.z - ATAN_DEG24[STAGE_IDX];
        end else begin
            st_next.x = st_in.x + dx;
            st_next.y = st_in.y - dy;
            st_next.z = st_in.z + ATAN_DEG24[STAGE_IDX];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctrl_in.valid;
        end
    end

    // Hand state and vertex to the next cell
    always_ff @(posedge aclk) begin
        if (en) begin
            flip_reg <= ctrl_in.flip;
            axis_reg <= ctrl_in.axis;
            st_reg   <= st_next;
            vtx_reg  <= vtx_in;
        end
    end

    assign ctrl_out = '{valid: valid_reg, flip: flip_reg, axis: axis_reg};
    assign st_out   = st_reg;
    assign vtx_out  = vtx_reg;

endmodule

// File: rtl/vxrot_apply.sv
// Applies cosine and sine to the vertex: select, multiply, round, saturate.
module vxrot_apply #(
    parameter int CW = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  vxrot_pkg::cell_ctrl_t ctrl_in,
    input  vxrot_pkg::cordic_t    st_in,
    input  logic [3*CW-1:0]       vtx_in,
    output logic                  res_valid,
    output logic [3*CW-1:0]       res_vtx,
    output logic                  res_clipped
);
    import vxrot_pkg::*;

    localparam int PW = CORDIC_WIDTH + CW;
    localparam int SW = PW + 1;
    localparam int QW = SW - 30;
    localparam logic signed [SW-1:0] RND_HALF = SW'(64'd1 << 29);
    localparam logic signed [QW-1:0] QMAX = QW'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic signed [QW-1:0] QMIN = -QMAX - QW'(1);

    // Stage 1: sign-corrected cosine and sine, rotation-plane operands
    logic                           v1_reg, v2_reg, v3_reg;
    axis_t                          axis1_reg, axis2_reg;
    logic [3*CW-1:0]                vtx1_reg, vtx2_reg;
    logic signed [CORDIC_WIDTH-1:0] c_next, s_next, c_reg, s_reg;
    logic signed [CW-1:0]           a_next, b_next, a_reg, b_reg;
    logic signed [CW-1:0]           vx, vy, vz;

    // Stage 2: products
    logic signed [PW-1:0]           ca_reg, sb_reg, sa_reg, cb_reg;

    // Stage 3: result
    logic signed [SW-1:0]           sum_a, sum_b;
    logic signed [QW-1:0]           q_a, q_b;
    logic signed [CW-1:0]           out_a, out_b;
    logic                           clip_a, clip_b;
    logic [3*CW-1:0]                vtx_next, vtx3_reg;
    logic                           clip_next, clip_reg;

    assign vx = $signed(vtx_in[CW-1:0]);
    assign vy = $signed(vtx_in[2*CW-1:CW]);
    assign vz = $signed(vtx_in[3*CW-1:2*CW]);

    // Negate for half-turn folds; pick (a, b) with a' = c*a - s*b, b' = s*a + c*b
    always_comb begin
        c_next = ctrl_in.flip ? -st_in.x : st_in.x;
        s_next = ctrl_in.flip ? -st_in.y : st_in.y;
        unique case (ctrl_in.axis)
            AXIS_X: begin
                a_next = vy;
                b_next = vz;
            end
            AXIS_Y: begin
                a_next = vz;
                b_next = vx;
            end
            AXIS_Z: begin
                a_next = vx;
                b_next = vy;
            end
            default: begin
                a_next = vx;
                b_next = vy;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= ctrl_in.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg     <= c_next;
            s_reg     <= s_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            axis1_reg <= ctrl_in.axis;
            vtx1_reg  <= vtx_in;
        end
    end

    // Register the four products
    always_ff @(posedge aclk) begin
        if (en) begin
            ca_reg    <= c_reg * a_reg;
            sb_reg    <= s_reg * b_reg;
            sa_reg    <= s_reg * a_reg;
            cb_reg    <= c_reg * b_reg;
            axis2_reg <= axis1_reg;
            vtx2_reg  <= vtx1_reg;
        end
    end

    // Sum, round half up to Q7.8, saturate
    always_comb begin
        sum_a = SW'(ca_reg) - SW'(sb_reg) + RND_HALF;
        sum_b = SW'(sa_reg) + SW'(cb_reg) + RND_HALF;
        q_a   = sum_a[SW-1:30];
        q_b   = sum_b[SW-1:30];
        clip_a = 1'b0;
        clip_b = 1'b0;
        if (q_a > QMAX) begin
            out_a  = QMAX[CW-1:0];
            clip_a = 1'b1;
        end else if (q_a < QMIN) begin
            out_a  = QMIN[CW-1:0];
            clip_a = 1'b1;
        end else begin
            out_a = q_a[CW-1:0];
        end
        if (q_b > QMAX) begin
            out_b  = QMAX[CW-1:0];
            clip_b = 1'b1;
        end else if (q_b < QMIN) begin
            out_b  = QMIN[CW-1:0];
            clip_b = 1'b1;
        end else begin
            out_b = q_b[CW-1:0];
        end
    end

    // Put the rotated pair back in place; the axis coordinate passes
    always_comb begin
        vtx_next  = vtx2_reg;
        clip_next = clip_a | clip_b;
        unique case (axis2_reg)
            AXIS_X: begin
                vtx_next[2*CW-1:CW]   = out_a;
                vtx_next[3*CW-1:2*CW] = out_b;
            end
            AXIS_Y: begin
                vtx_next[3*CW-1:2*CW] = out_a;
                vtx_next[CW-1:0]      = out_b;
            end
            AXIS_Z: begin
                vtx_next[CW-1:0]      = out_a;
                vtx_next[2*CW-1:CW]   = out_b;
            end
            default: begin
                clip_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vtx3_reg <= vtx_next;
            clip_reg <= clip_next;
        end
    end

    assign res_valid   = v3_reg;
    assign res_vtx     = vtx3_reg;
    assign res_clipped = clip_reg;

endmodule

// File: rtl/vertex_axis_rotate_unit.sv
// Top level of the vertex rotation block: angle fold, CORDIC cell chain, apply, output skid.
//
// Usage:
//   Each input transfer on s_axis carries one vertex (x, y, z in signed Q7.8)
//   and an angle in signed 1/16 degree in tdata, with the axis code in tuser
//   (0 about x, 1 about y, 2 about z, 3 pass through). Each produces exactly
//   one result transfer on m_axis: the rotated vertex in tdata and a
//   saturation flag in tuser.
//   From input transfer to m_axis_tvalid a vertex passes the angle reduction,
//   the CORDIC cells, the multiply, round and saturate registers, and the
//   output register. Throughput is one vertex per cycle while no result is
//   parked in the skid register; the chain of CORDIC cells sets the depth,
//   each cell doing one micro-rotation per cycle.
//   When the receiver stalls, one finished result parks in a skid register
//   and the whole pipeline then holds; s_axis_tready drops until the skid
//   register drains. s_axis_tready comes straight from a register.
//   Synchronous active-low reset empties the pipeline and the output; the
//   block keeps no other state.
module vertex_axis_rotate_unit #(
    parameter int COORD_WIDTH    = 16,
    parameter int ROTATOR_STAGES = 16
) (
    input  logic aclk,
    input  logic aresetn,
    // coord_x, coord_y, coord_z, angle_deg from bit 0 up, zero padded
    input  logic [((3*COORD_WIDTH+vxrot_pkg::ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // axis_code
    input  logic [1:0] s_axis_tuser,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // rot_x, rot_y, rot_z from bit 0 up, zero padded
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // clipped
    output logic [0:0] m_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready
);
    import vxrot_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int OUT_W = ((3 * CW + 7) / 8) * 8;

    logic            pipe_en;
    logic [3*CW-1:0] vtx_in;
    axis_t           axis_in;

    cell_ctrl_t      chain_ctrl [ROTATOR_STAGES+1];
    cordic_t         chain_st   [ROTATOR_STAGES+1];
    logic [3*CW-1:0] chain_vtx  [ROTATOR_STAGES+1];

    logic            res_valid;
    logic [3*CW-1:0] res_vtx;
    logic            res_clipped;

    logic            out_valid_reg;
    logic [3*CW-1:0] out_vtx_reg;
    logic            out_clip_reg;
    logic            skid_full_reg;
    logic [3*CW-1:0] skid_vtx_reg;
    logic            skid_clip_reg;
    logic            out_free;
    logic            res_take;

    assign vtx_in  = s_axis_tdata[3*CW-1:0];
    assign axis_in = axis_t'(s_axis_tuser);

    // Advance the whole pipeline unless a result is parked in the skid
    assign pipe_en       = !skid_full_reg;
    assign s_axis_tready = pipe_en;

    vxrot_angle_fold #(
        .CW(CW)
    ) u_fold (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .in_valid(s_axis_tvalid),
        .angle   (s_axis_tdata[3*CW+ANGLE_WIDTH-1:3*CW]),
        .axis    (axis_in),
        .vtx     (vtx_in),
        .ctrl_out(chain_ctrl[0]),
        .st_out  (chain_st[0]),
        .vtx_out (chain_vtx[0])
    );

    // Chain of CORDIC cells, one micro-rotation each
    for (genvar i = 0; i < ROTATOR_STAGES; i++) begin : g_cell
        vxrot_cordic_cell #(
            .CW       (CW),
            .STAGE_IDX(i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (pipe_en),
            .ctrl_in (chain_ctrl[i]),
            .st_in   (chain_st[i]),
            .vtx_in  (chain_vtx[i]),
            .ctrl_out(chain_ctrl[i+1]),
            .st_out  (chain_st[i+1]),
            .vtx_out (chain_vtx[i+1])
        );
    end

    vxrot_apply #(
        .CW(CW)
    ) u_apply (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (pipe_en),
        .ctrl_in    (chain_ctrl[ROTATOR_STAGES]),
        .st_in      (chain_st[ROTATOR_STAGES]),
        .vtx_in     (chain_vtx[ROTATOR_STAGES]),
        .res_valid  (res_valid),
        .res_vtx    (res_vtx),
        .res_clipped(res_clipped)
    );

    assign out_free = !out_valid_reg || m_axis_tready;
    assign res_take = pipe_en && res_valid;

    // Output register with one-entry skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_full_reg) begin
                out_valid_reg <= 1'b1;
                skid_full_reg <= 1'b0;
            end else begin
                out_valid_reg <= res_take;
            end
        end else if (res_take) begin
            skid_full_reg <= 1'b1;
        end
    end

    // Move payload into the output or park it in the skid
    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_full_reg) begin
                out_vtx_reg  <= skid_vtx_reg;
                out_clip_reg <= skid_clip_reg;
            end else if (res_take) begin
                out_vtx_reg  <= res_vtx;
                out_clip_reg <= res_clipped;
            end
        end else if (res_take) begin
            skid_vtx_reg  <= res_vtx;
            skid_clip_reg <= res_clipped;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = OUT_W'(out_vtx_reg);
    assign m_axis_tuser[0] = out_clip_reg;

endmodule

// File: test/tb_vertex_axis_rotate_unit.sv
// Self-checking testbench for the vertex axis rotation block with streaming handshakes.
module tb_vertex_axis_rotate_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import vxrot_pkg::*;

    localparam int COORD_W = 16;
    localparam int STAGES = 16;
    localparam int S_DATA_W = ((3*COORD_W + ANGLE_WIDTH + 7) / 8) * 8;
    localparam int M_DATA_W = ((3*COORD_W + 7) / 8) * 8;
    localparam int RANDOM_VERTICES = 700;
    localparam int DRAIN_CYCLES = STAGES + 6 + 16;
    localparam int CYCLE_LIMIT = 200000;

    // Angle fold points in 1/16 degree and coordinate bounds, as signed 64-bit values
    localparam longint TURN = DEG_FULL_INT;
    localparam longint HALF_TURN = longint'(DEG_HALF);
    localparam longint QUARTER_TURN = longint'(DEG_QUARTER);
    localparam longint COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    typedef struct {
        logic signed [COORD_W-1:0]     x;
        logic signed [COORD_W-1:0]     y;
        logic signed [COORD_W-1:0]     z;
        logic signed [ANGLE_WIDTH-1:0] angle;
        axis_t                         axis;
    } vertex_t;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      clipped;
    } rotated_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic [1:0]          s_axis_tuser = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [0:0]          m_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;

    vertex_t  vertex_q[$];
    rotated_t rotated_expect_q[$];

    logic vtx_taken = 1'b0;
    logic res_taken = 1'b0;
    logic drv_busy = 1'b0;
    int   drv_gap = 0;
    int   drv_calm = 0;
    int   rcv_stall = 0;
    int   rcv_calm = 0;
    int   cycle_count = 0;
    int   error_count = 0;
    int   results_checked = 0;
    int   clipped_count = 0;
    int   axis_hits[4] = '{0, 0, 0, 0};

    vertex_axis_rotate_unit #(
        .COORD_WIDTH(COORD_W),
        .ROTATOR_STAGES(STAGES)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready)
    );

    // 12 ns clock
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Cosine and sine in Q30 of an angle in 1/16 degree, folded to +-90 degrees
    function automatic void angle_sin_cos(input logic signed [ANGLE_WIDTH-1:0] angle,
                                          output longint cos_q30, output longint sin_q30);
        longint a;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        int     i;
        a = longint'(angle) % TURN;
        flip = 1'b0;
        if (a < 0) a = a + TURN;
        if (a >= HALF_TURN) a = a - TURN;
        if (a > QUARTER_TURN) begin
            a = a - HALF_TURN;
            flip = 1'b1;
        end else if (a < -QUARTER_TURN) begin
            a = a + HALF_TURN;
            flip = 1'b1;
        end
        x = CORDIC_GAIN_Q30;
        y = 0;
        z = a * 64'sd1048576;
        // Micro-rotations toward zero residual angle
        for (i = 0; i < STAGES && i < ATAN_TABLE_SIZE; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_DEG24[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_DEG24[i];
            end
        end
        cos_q30 = flip ? -x : x;
        sin_q30 = flip ? -y : y;
    endfunction

    // Round a Q30-scaled sum half up to Q7.8 and clamp to the coordinate range
    function automatic logic signed [COORD_W-1:0] round_clamp(input longint acc,
                                                              inout logic clip);
        longint v;
        v = (acc + (64'sd1 <<< 29)) >>> 30;
        if (v > COORD_MAX) begin
            v = COORD_MAX;
            clip = 1'b1;
        end
        if (v < COORD_MIN) begin
            v = COORD_MIN;
            clip = 1'b1;
        end
        return COORD_W'(v);
    endfunction

    function automatic rotated_t rotate_vertex(input vertex_t v);
        rotated_t r;
        longint   c;
        longint   s;
        longint   px;
        longint   py;
        longint   pz;
        logic     clip;
        r.x = v.x;
        r.y = v.y;
        r.z = v.z;
        r.clipped = 1'b0;
        clip = 1'b0;
        px = v.x;
        py = v.y;
        pz = v.z;
        if (v.axis != AXIS_PASS) begin
            angle_sin_cos(v.angle, c, s);
            case (v.axis)
                AXIS_X: begin
                    r.y = round_clamp(c * py - s * pz, clip);
                    r.z = round_clamp(s * py + c * pz, clip);
                end
                AXIS_Y: begin
                    r.x = round_clamp(c * px + s * pz, clip);
                    r.z = round_clamp(c * pz - s * px, clip);
                end
                default: begin
                    r.x = round_clamp(c * px - s * py, clip);
                    r.y = round_clamp(s * px + c * py, clip);
                end
            endcase
            r.clipped = clip;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Idle length for one item; runs of zero keep the pipeline full now and then
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    task automatic add_vertex(input int x, input int y, input int z, input int angle,
                              input axis_t axis);
        vertex_t v;
        v.x = COORD_W'(x);
        v.y = COORD_W'(y);
        v.z = COORD_W'(z);
        v.angle = ANGLE_WIDTH'(angle);
        v.axis = axis;
        vertex_q = {vertex_q, v};
    endtask

    function automatic int random_coord();
        int r;
        r = $urandom_range(0, 255);
        case ($urandom_range(0, 9))
            0, 1: return 32767 - r;
            2, 3: return -32768 + r;
            default: return $signed(16'($urandom()));
        endcase
    endfunction

    function automatic int random_angle();
        int off;
        off = $urandom_range(0, 4) - 2;
        case ($urandom_range(0, 9))
            0, 1: return $urandom_range(0, 44) * 1440 - 22 * 1440 + off;
            2: begin
                case ($urandom_range(0, 5))
                    0: return 1440 + off;
                    1: return -1440 + off;
                    2: return 2880 + off;
                    3: return -2880 + off;
                    4: return 5760 + off;
                    default: return 32767 - $urandom_range(0, 3);
                endcase
            end
            default: return $signed(16'($urandom()));
        endcase
    endfunction

    // Record handshakes at the rising edge for the falling-edge drivers
    always @(posedge aclk) begin
        vtx_taken <= aresetn && s_axis_tvalid && s_axis_tready;
        res_taken <= aresetn && m_axis_tvalid && m_axis_tready;
    end

    // Predict each accepted vertex
    always @(posedge aclk) begin : accept_blk
        vertex_t v;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            v.x = s_axis_tdata[0 +: COORD_W];
            v.y = s_axis_tdata[COORD_W +: COORD_W];
            v.z = s_axis_tdata[2*COORD_W +: COORD_W];
            v.angle = s_axis_tdata[3*COORD_W +: ANGLE_WIDTH];
            v.axis = axis_t'(s_axis_tuser);
            axis_hits[v.axis]++;
            rotated_expect_q = {rotated_expect_q, rotate_vertex(v)};
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge aclk) begin : check_blk
        rotated_t want;
        rotated_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.x = m_axis_tdata[0 +: COORD_W];
            got.y = m_axis_tdata[COORD_W +: COORD_W];
            got.z = m_axis_tdata[2*COORD_W +: COORD_W];
            got.clipped = m_axis_tuser[0];
            if (rotated_expect_q.size() == 0) begin
                report_mismatch("result transfer with no vertex outstanding");
            end else begin
                want = rotated_expect_q.pop_front();
                if (got.x !== want.x)
                    report_mismatch($sformatf("result %0d rot_x got %0d expected %0d",
                                              results_checked, got.x, want.x));
                if (got.y !== want.y)
                    report_mismatch($sformatf("result %0d rot_y got %0d expected %0d",
                                              results_checked, got.y, want.y));
                if (got.z !== want.z)
                    report_mismatch($sformatf("result %0d rot_z got %0d expected %0d",
                                              results_checked, got.z, want.z));
                if (got.clipped !== want.clipped)
                    report_mismatch($sformatf("result %0d clipped got %b expected %b",
                                              results_checked, got.clipped, want.clipped));
                if (want.clipped) clipped_count++;
                results_checked++;
            end
        end
    end

    // Drive vertices, holding each until its transfer, then idle
    always @(negedge aclk) begin : drive_blk
        vertex_t v;
        if (aresetn) begin
            if (s_axis_tvalid && vtx_taken) drv_busy = 1'b0;
            if (!drv_busy) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                end else if (vertex_q.size() > 0) begin
                    v = vertex_q.pop_front();
                    s_axis_tdata <= S_DATA_W'({v.angle, v.z, v.y, v.x});
                    s_axis_tuser <= v.axis;
                    drv_busy = 1'b1;
                    drv_gap = draw_wait(drv_calm);
                end
            end
            s_axis_tvalid <= drv_busy;
        end
    end

    // Stall the result side for a random number of cycles after each transfer
    always @(negedge aclk) begin
        if (aresetn) begin
            if (res_taken) rcv_stall = draw_wait(rcv_calm);
            if (rcv_stall > 0) begin
                m_axis_tready <= 1'b0;
                rcv_stall--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, rotated_expect_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        // Pass through keeps extremes untouched
        add_vertex(-32768, 32767, 21845, 1440, AXIS_PASS);
        add_vertex(32767, -32768, -1, -32768, AXIS_PASS);
        // Zero angle about each axis at the coordinate extremes
        add_vertex(32767, -32768, 32767, 0, AXIS_X);
        add_vertex(-32768, 32767, -32768, 0, AXIS_Y);
        add_vertex(32767, 32767, -32768, 0, AXIS_Z);
        // Quarter and half turns of both signs, three-quarter and full turns, and near neighbours
        add_vertex(256, 512, -768, 1440, AXIS_X);
        add_vertex(256, 512, -768, -1440, AXIS_Y);
        add_vertex(256, 512, -768, 2880, AXIS_Z);
        add_vertex(256, 512, -768, -2880, AXIS_X);
        add_vertex(256, 512, -768, 4320, AXIS_Y);
        add_vertex(256, 512, -768, 5760, AXIS_Z);
        add_vertex(1000, -2000, 3000, 1441, AXIS_Z);
        add_vertex(1000, -2000, 3000, -1441, AXIS_X);
        add_vertex(1000, -2000, 3000, 2879, AXIS_Y);
        // Angle field extremes and the smallest step
        add_vertex(12345, -6789, 4321, 32767, AXIS_X);
        add_vertex(12345, -6789, 4321, -32768, AXIS_Y);
        add_vertex(12345, -6789, 4321, 1, AXIS_Z);
        add_vertex(12345, -6789, 4321, -1, AXIS_Z);
        // 45 degrees on large vectors drives results past both bounds
        add_vertex(32767, 32767, 0, 720, AXIS_Z);
        add_vertex(-32768, -32768, 0, 720, AXIS_Z);
        add_vertex(0, 32767, -32768, 720, AXIS_X);
        add_vertex(-32768, 0, 32767, 720, AXIS_Y);
        // Rounding of tiny coordinates
        add_vertex(1, -1, 1, 480, AXIS_Z);
        add_vertex(-1, 1, -1, 2000, AXIS_X);

        for (int n = 0; n < RANDOM_VERTICES; n++) begin
            add_vertex(random_coord(), random_coord(), random_coord(), random_angle(),
                       ($urandom_range(0, 9) == 0) ? AXIS_PASS
                                                   : axis_t'($urandom_range(0, 2)));
        end
        drv_gap = draw_wait(drv_calm);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for every vertex to go out and every result to come back
        while (vertex_q.size() != 0 || s_axis_tvalid || rotated_expect_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (rotated_expect_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", rotated_expect_q.size()));

        $display("Covered %0d vertices: %0d about x, %0d about y, %0d about z, %0d passed",
                 results_checked, axis_hits[AXIS_X], axis_hits[AXIS_Y], axis_hits[AXIS_Z],
                 axis_hits[AXIS_PASS]);
        $display("Saturated results: %0d, mismatches: %0d", clipped_count, error_count);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/vxrot_pkg.sv
rtl/vxrot_angle_fold.sv
rtl/vxrot_cordic_cell.sv
rtl/vxrot_apply.sv
rtl/vertex_axis_rotate_unit.sv
test/tb_vertex_axis_rotate_unit.sv
